/* sv/assert_macros.svh */
// assertion macros used by the checker file sha256_md_chk
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// assertion on the default clock clk_i and reset rst_ni
`define ASSERT_STD(label, prop) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

/* sv/sha256_md_pkg.sv */
// types, constants and round functions for the sha-256 digest block
// no dependencies
package sha256_md_pkg;

  localparam int unsigned NumWords     = 8;
  localparam int unsigned NumSchedule  = 16;
  localparam logic [2:0]  LastWordIdx  = 3'd7;
  localparam logic [5:0]  LastRound    = 6'd63;
  localparam logic [5:0]  LastByte     = 6'd63;
  localparam logic [5:0]  LengthStart  = 6'd56;
  localparam logic [7:0]  PadMarker    = 8'h80;

  typedef logic [31:0] word_t;

  localparam word_t InitHash [NumWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

/* sv/sha256_message_digest.sv */
// sha-256 digest over a byte stream, one shared round unit
// depends on sha256_md_pkg
// An input item carrying a byte is taken while the block is idle; bytes shift into a
// 16-word block register that also serves as the message schedule window. The item
// that completes a 64-byte block holds the input stalled through 64 rounds on the
// single round unit and then the chain update. An end-of-message item then shifts
// the padding and length in one byte per cycle up to the block end, runs one
// compression, or two when fewer than 9 bytes remain in the block, and finally emits
// the eight digest words, word 0 first, one per cycle unless stalled. No input is
// taken until the last word leaves; the block is then set back to the initial hash
// for the next message.
module sha256_message_digest
  import sha256_md_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_OUT
  } state_e;

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [5:0]  round_q, round_d;
  logic [63:0] len_q, len_d;
  logic        pad_q, pad_d;
  logic        first_q, first_d;
  logic        final_q, final_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_idx_q, out_idx_d;
  word_t       chain_q [NumWords];
  word_t       chain_d [NumWords];
  word_t       v_q [NumWords];
  word_t       v_d [NumWords];
  word_t       w_q [NumSchedule];
  word_t       w_d [NumSchedule];

  word_t       t1, t2, w_new;
  logic [7:0]  pad_byte;
  logic        shift_en;
  logic [7:0]  shift_byte;

  // round unit
  always_comb begin
    t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + RoundK[round_q] + w_q[0];
    t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_new = w_q[0] + small_sigma0(w_q[1]) + w_q[9] + small_sigma1(w_q[14]);
  end

  // padding byte: marker first, length bytes at the tail of the final block
  always_comb begin
    if (first_q) begin
      pad_byte = PadMarker;
    end else if (final_q && (fill_q >= LengthStart)) begin
      pad_byte = len_q[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    round_d     = round_q;
    len_d       = len_q;
    pad_d       = pad_q;
    first_d     = first_q;
    final_d     = final_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    chain_d     = chain_q;
    v_d         = v_q;
    w_d         = w_q;
    shift_en    = 1'b0;
    shift_byte  = data_byte_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (has_byte_i) begin
            shift_en = 1'b1;
            len_d    = len_q + 64'd8;
            fill_d   = fill_q + 6'd1;
          end
          if (end_of_message_i) begin
            pad_d   = 1'b1;
            first_d = 1'b1;
          end
          if (has_byte_i && (fill_q == LastByte)) begin
            v_d     = chain_q;
            round_d = '0;
            state_d = ST_ROUND;
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        shift_en   = 1'b1;
        shift_byte = pad_byte;
        fill_d     = fill_q + 6'd1;
        if (first_q) begin
          first_d = 1'b0;
          final_d = (fill_q < LengthStart);
        end else if (final_q && (fill_q >= LengthStart)) begin
          len_d = {len_q[55:0], 8'h00};
        end
        if (fill_q == LastByte) begin
          v_d     = chain_q;
          round_d = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        for (int i = 0; i < NumSchedule - 1; i++) begin
          w_d[i] = w_q[i + 1];
        end
        w_d[NumSchedule - 1] = w_new;
        round_d = round_q + 6'd1;
        if (round_q == LastRound) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < NumWords; i++) begin
          chain_d[i] = chain_q[i] + v_q[i];
        end
        if (!pad_q) begin
          state_d = ST_IDLE;
        end else if (final_q) begin
          out_valid_d = 1'b1;
          out_idx_d   = '0;
          state_d     = ST_OUT;
        end else begin
          // marker did not leave room for the length: one more block
          final_d = 1'b1;
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          if (out_idx_q == LastWordIdx) begin
            out_valid_d = 1'b0;
            chain_d     = InitHash;
            len_d       = '0;
            fill_d      = '0;
            pad_d       = 1'b0;
            first_d     = 1'b0;
            final_d     = 1'b0;
            state_d     = ST_IDLE;
          end else begin
            out_idx_d = out_idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // byte shift into the block register, first byte ends up in word 0 msb
    if (shift_en) begin
      for (int i = 0; i < NumSchedule - 1; i++) begin
        w_d[i] = {w_q[i][23:0], w_q[i + 1][31:24]};
      end
      w_d[NumSchedule - 1] = {w_q[NumSchedule - 1][23:0], shift_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      round_q     <= '0;
      len_q       <= '0;
      pad_q       <= 1'b0;
      first_q     <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      chain_q     <= InitHash;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      round_q     <= round_d;
      len_q       <= len_d;
      pad_q       <= pad_d;
      first_q     <= first_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      chain_q     <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign digest_word_o = chain_q[out_idx_q];
  assign word_index_o  = out_idx_q;
  assign last_word_o   = (out_idx_q == LastWordIdx);

endmodule

/* sv/sha256_md_chk.sv */
// port-level checker for the sha-256 digest block, bound to the top level
// depends on sha256_md_pkg and assert_macros.svh
`include "assert_macros.svh"

module sha256_md_chk
  import sha256_md_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        end_of_message_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  // no item is taken while the digest is going out
  `ASSERT_STD(a_no_input_during_out, out_valid_o |-> in_stall_o)

  `ASSERT_STD(a_last_flag, out_valid_o |-> (last_word_o == (word_index_o == LastWordIdx)))

  // words leave in order without gaps
  `ASSERT_STD(a_word_order, out_valid_o && !out_stall_i && !last_word_o |=> out_valid_o && (word_index_o == $past(word_index_o) + 3'd1))

  `ASSERT_STD(a_done_after_last, out_valid_o && !out_stall_i && last_word_o |=> !out_valid_o)

  // an item without end mark gives no result
  `ASSERT_STD(a_no_spurious_out, in_valid_i && !in_stall_o && !end_of_message_i |=> !out_valid_o)

endmodule

bind sha256_message_digest sha256_md_chk u_sha256_md_chk (.*);

/* tb/sha256_digest_checker.sv */
// digest checker for sha256_message_digest: predicts the sha-256 digest of every
// message from the accepted input items and compares each accepted digest word in order
// depends on sha256_md_pkg for the word type
module sha256_digest_checker
  import sha256_md_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_words_o,
  output int unsigned words_checked_o,
  output int unsigned digests_predicted_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIGEST_WORDS = 8;
  localparam int unsigned BLOCK_SIZE   = 64;
  localparam int unsigned LENGTH_POS   = 56;
  localparam logic [7:0]  PAD_MARKER   = 8'h80;
  localparam int unsigned REPORT_LIMIT = 10;

  localparam word_t HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    word_t      word;
    logic [2:0] index;
    logic       is_last;
  } digest_word_t;

  word_t        chain [8];
  logic [63:0]  bit_count;
  logic [7:0]   block_buf [64];
  int unsigned  fill;
  digest_word_t expected_words [$];

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    word_t       sched [64];
    word_t       v [8];
    word_t       t1;
    word_t       t2;
    int unsigned t;
    for (t = 0; t < 16; t++) begin
      sched[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    end
    for (t = 16; t < 64; t++) begin
      sched[t] = sched[t-16] + sched[t-7]
               + (rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3))
               + (rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10));
    end
    for (t = 0; t < 8; t++) v[t] = chain[t];
    for (t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + sched[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (t = 0; t < 8; t++) chain[t] = chain[t] + v[t];
  endfunction

  function automatic void restart_message();
    int unsigned i;
    for (i = 0; i < DIGEST_WORDS; i++) chain[i] = HASH_IV[i];
    bit_count = '0;
    fill      = 0;
  endfunction

  function automatic void absorb_item(logic [7:0] data, logic has_data, logic msg_end);
    int unsigned  i;
    digest_word_t entry;
    if (has_data) begin
      block_buf[fill] = data;
      bit_count       = bit_count + 64'd8;
      fill++;
      if (fill == BLOCK_SIZE) begin
        compress_block();
        fill = 0;
      end
    end
    if (msg_end) begin
      block_buf[fill] = PAD_MARKER;
      fill++;
      // length field does not fit: close this block and pad a fresh one
      if (fill > LENGTH_POS) begin
        for (i = fill; i < BLOCK_SIZE; i++) block_buf[i] = 8'h00;
        compress_block();
        fill = 0;
      end
      for (i = fill; i < LENGTH_POS; i++) block_buf[i] = 8'h00;
      for (i = 0; i < 8; i++) block_buf[LENGTH_POS + i] = bit_count[63 - 8*i -: 8];
      compress_block();
      for (i = 0; i < DIGEST_WORDS; i++) begin
        entry.word    = chain[i];
        entry.index   = 3'(i);
        entry.is_last = (i == DIGEST_WORDS - 1);
        expected_words.push_back(entry);
      end
      digests_predicted_o++;
      restart_message();
    end
  endfunction

  function automatic void report_mismatch(string what, digest_word_t exp_w, digest_word_t act_w);
    mismatch_count_o++;
    if (mismatch_count_o <= REPORT_LIMIT) begin
      $display("[%0t] digest word %s: expected %h idx %0d last %0b, got %h idx %0d last %0b",
               $time, what, exp_w.word, exp_w.index, exp_w.is_last,
               act_w.word, act_w.index, act_w.is_last);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    digest_word_t act_w;
    digest_word_t exp_w;
    if (!rst_ni) begin
      restart_message();
      expected_words.delete();
      pending_words_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        absorb_item(data_byte_i, has_byte_i, end_of_message_i);
      end
      if (out_valid_i && !out_stall_i) begin
        act_w.word    = digest_word_i;
        act_w.index   = word_index_i;
        act_w.is_last = last_word_i;
        if (expected_words.size() == 0) begin
          report_mismatch("with nothing expected", '0, act_w);
        end else begin
          exp_w = expected_words.pop_front();
          words_checked_o++;
          if (act_w !== exp_w) report_mismatch("differs", exp_w, act_w);
        end
      end
      pending_words_o = expected_words.size();
    end
  end

endmodule

/* tb/sha256_message_digest_tb.sv */
// testbench top for sha256_message_digest: resets the block, sends directed and random
// messages under three idle profiles and prints the verdict
// depends on sha256_md_pkg, sha256_message_digest and sha256_digest_checker
module sha256_message_digest_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam time         HALF_PERIOD   = 5ns;
  localparam int unsigned RESET_CYCLES  = 5;
  localparam int unsigned RANDOM_ITEMS  = 260;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam time         RUN_LIMIT     = 3ms;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i      = 8'h00;
  logic        has_byte_i       = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned data_items    = 0;
  int unsigned noise_items   = 0;
  int unsigned messages_sent = 0;
  int unsigned mismatch_count;
  int unsigned pending_words;
  int unsigned words_checked;
  int unsigned digests_predicted;

  int unsigned boundary_len [6] = '{55, 56, 57, 63, 64, 65};

  always #(HALF_PERIOD) clk_i = ~clk_i;

  sha256_message_digest uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digest_word_o    (digest_word_o),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o)
  );

  sha256_digest_checker digest_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .data_byte_i         (data_byte_i),
    .has_byte_i          (has_byte_i),
    .end_of_message_i    (end_of_message_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .digest_word_i       (digest_word_o),
    .word_index_i        (word_index_o),
    .last_word_i         (last_word_o),
    .mismatch_count_o    (mismatch_count),
    .pending_words_o     (pending_words),
    .words_checked_o     (words_checked),
    .digests_predicted_o (digests_predicted)
  );

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // present one item at the falling edge and hold it until the block takes it
  task automatic send_item(logic [7:0] data, logic has_data, logic msg_end);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    data_byte_i      = data;
    has_byte_i       = has_data;
    end_of_message_i = msg_end;
    do @(posedge clk_i); while (in_stall_o);
    if (has_data || msg_end) data_items++;
    else noise_items++;
    if (msg_end) messages_sent++;
  endtask

  // random bytes with some ignored items mixed in; the end mark rides on the
  // last byte or comes as an item of its own
  task automatic send_message(int unsigned len, bit end_on_byte);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) return $urandom_range(15);
    if (r < 8) return boundary_len[$urandom_range(5)];
    return $urandom_range(130);
  endfunction

  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct,
                           int unsigned first_len, int unsigned item_goal);
    int unsigned start;
    int unsigned len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start         = data_items + noise_items;
    send_message(first_len, bit'($urandom_range(1)));
    // later messages are cut short so the phase ends close to its item goal
    while (data_items + noise_items - start < item_goal) begin
      len = pick_length();
      if (len > item_goal - (data_items + noise_items - start)) begin
        len = item_goal - (data_items + noise_items - start);
      end
      send_message(len, bit'($urandom_range(1)));
    end
  endtask

  initial begin : stimulus
    int unsigned drain_cycles;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni        = 1'b1;
    send_idle_pct = 16;
    recv_idle_pct = 71;

    // empty message
    send_item(8'h00, 1'b0, 1'b1);
    // short text with the end mark on its last byte
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // byte extremes, an ignored item, then an end item with no byte
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);

    // first messages hit one-block padding, the spill-over block and a full block
    run_phase(16, 71, 55, RANDOM_ITEMS / 3);
    run_phase(71, 16, 56, RANDOM_ITEMS / 3);
    run_phase(0, 0, 64, RANDOM_ITEMS / 3);

    @(negedge clk_i);
    in_valid_i       = 1'b0;
    has_byte_i       = 1'b0;
    end_of_message_i = 1'b0;

    drain_cycles = 0;
    while (pending_words != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    if (pending_words != 0) begin
      $display("%0d digest words never arrived", pending_words);
      $display("Regression FAIL");
      $finish;
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      $display("sent %0d messages: %0d byte or end items, %0d ignored items, three idle mixes",
               messages_sent, data_items, noise_items);
      $display("compared %0d digest words of %0d digests, %0d mismatches",
               words_checked, digests_predicted, mismatch_count);
      if (mismatch_count == 0) begin
        $display("Regression PASS");
      end else begin
        $display("Regression FAIL");
      end
      $finish;
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("run limit reached");
    $display("Regression FAIL");
    $finish;
  end

endmodule
